>>> rtl/legv8_pkg.sv
// ----------------------------------------------------------------------------
// legv8 execute unit package
// opcodes, widths and shared types
// ----------------------------------------------------------------------------
package legv8_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam logic [4:0] LINK_REG = 5'd30;
  localparam logic [4:0] ZERO_REG = 5'd31;
  localparam logic [4:0] STACK_REG = 5'd28;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_MUL = 6'd1, OP_ADDS = 6'd2, OP_ADDI = 6'd3, OP_ADDIS = 6'd4,
    OP_SUB = 6'd5, OP_SUBS = 6'd6, OP_SUBI = 6'd7, OP_SUBIS = 6'd8,
    OP_LDUR = 6'd9, OP_LDURH = 6'd10, OP_LDURB = 6'd11,
    OP_STUR = 6'd12, OP_STURH = 6'd13, OP_STURB = 6'd14,
    OP_AND = 6'd15, OP_ANDS = 6'd16, OP_ANDI = 6'd17, OP_ANDIS = 6'd18,
    OP_CBZ = 6'd19, OP_CBNZ = 6'd20, OP_B = 6'd21, OP_BL = 6'd22, OP_BR = 6'd23,
    OP_BEQ = 6'd24, OP_BNE = 6'd25, OP_BHS = 6'd26, OP_BLO = 6'd27, OP_BMI = 6'd28,
    OP_BPL = 6'd29, OP_BVS = 6'd30, OP_BHI = 6'd31, OP_BLS = 6'd32, OP_BGE = 6'd33,
    OP_BLT = 6'd34, OP_BGT = 6'd35, OP_BLE = 6'd36,
    OP_LSL = 6'd37, OP_LSR = 6'd38, OP_EOR = 6'd39, OP_EORI = 6'd40,
    OP_ORR = 6'd41, OP_ORRI = 6'd42, OP_LDURW = 6'd43, OP_STURW = 6'd44
  } op_t;

  typedef enum logic [3:0] {
    K_ALU, K_MUL, K_SHIFT, K_LOAD, K_STORE, K_CB, K_B, K_BL, K_BR, K_BCOND, K_NOP
  } kind_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_ORR, ALU_EOR
  } alu_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_EXEC, ST_MEM, ST_MUL, ST_DONE
  } state_t;

  typedef struct packed {
    kind_t      kind;
    alu_t       alu;
    logic       use_imm;
    logic       set_flags;
    logic       shift_right;
    logic       cbnz;
    logic [3:0] nbytes;
    logic [5:0] op;
    logic [4:0] rt;
    logic [4:0] rn;
    logic [4:0] rm;
    logic [63:0] imm;
    logic [15:0] target;
  } uop_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [63:0] written_value;
    logic [3:0]  flags_nzcv;
    logic        finished;
  } res_t;

endpackage

>>> rtl/legv8_if.sv
// ----------------------------------------------------------------------------
// legv8 channels
// request, result and configuration handshake interfaces
// ----------------------------------------------------------------------------
interface legv8_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  req_type;
  logic [4:0]  target_reg;
  logic [4:0]  base_reg;
  logic [4:0]  other_reg;
  logic signed [31:0] immediate;
  logic [15:0] branch_target;
  modport source (output valid, req_type, target_reg, base_reg, other_reg, immediate,
                  branch_target, input ready);
  modport sink (input valid, req_type, target_reg, base_reg, other_reg, immediate,
                branch_target, output ready);
endinterface

interface legv8_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        reg_written;
  logic [4:0]  written_reg;
  logic signed [63:0] written_value;
  logic [3:0]  flags_nzcv;
  logic        finished;
  modport source (output valid, next_pc, reg_written, written_reg, written_value,
                  flags_nzcv, finished, input ready);
  modport sink (input valid, next_pc, reg_written, written_reg, written_value,
                flags_nzcv, finished, output ready);
endinterface

interface legv8_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/legv8_front.sv
// ----------------------------------------------------------------------------
// legv8 front end
// accepts requests, classifies them and queues the decoded operations
// ----------------------------------------------------------------------------
module legv8_front (
  input  logic clk,
  input  logic rst,
  legv8_req_if.sink req,
  output logic uop_valid,
  input  logic uop_ready,
  output legv8_pkg::uop_t uop
);

  legv8_pkg::uop_t dec;
  legv8_pkg::uop_t q [legv8_pkg::QUEUE_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  always_comb begin
    dec = '0;
    dec.op = req.req_type;
    dec.rt = req.target_reg;
    dec.rn = req.base_reg;
    dec.rm = req.other_reg;
    dec.imm = {{32{req.immediate[31]}}, req.immediate};
    dec.target = req.branch_target;
    dec.kind = legv8_pkg::K_NOP;
    dec.alu = legv8_pkg::ALU_ADD;
    dec.nbytes = 4'd0;
    case (req.req_type) inside
      legv8_pkg::OP_ADD, legv8_pkg::OP_ADDS, legv8_pkg::OP_ADDI, legv8_pkg::OP_ADDIS: begin
        dec.kind = legv8_pkg::K_ALU;
        dec.alu = legv8_pkg::ALU_ADD;
      end
      legv8_pkg::OP_SUB, legv8_pkg::OP_SUBS, legv8_pkg::OP_SUBI, legv8_pkg::OP_SUBIS: begin
        dec.kind = legv8_pkg::K_ALU;
        dec.alu = legv8_pkg::ALU_SUB;
      end
      legv8_pkg::OP_AND, legv8_pkg::OP_ANDS, legv8_pkg::OP_ANDI, legv8_pkg::OP_ANDIS: begin
        dec.kind = legv8_pkg::K_ALU;
        dec.alu = legv8_pkg::ALU_AND;
      end
      legv8_pkg::OP_EOR, legv8_pkg::OP_EORI: begin
        dec.kind = legv8_pkg::K_ALU;
        dec.alu = legv8_pkg::ALU_EOR;
      end
      legv8_pkg::OP_ORR, legv8_pkg::OP_ORRI: begin
        dec.kind = legv8_pkg::K_ALU;
        dec.alu = legv8_pkg::ALU_ORR;
      end
      legv8_pkg::OP_MUL: dec.kind = legv8_pkg::K_MUL;
      legv8_pkg::OP_LSL, legv8_pkg::OP_LSR: dec.kind = legv8_pkg::K_SHIFT;
      legv8_pkg::OP_LDUR, legv8_pkg::OP_LDURH, legv8_pkg::OP_LDURB, legv8_pkg::OP_LDURW:
        dec.kind = legv8_pkg::K_LOAD;
      legv8_pkg::OP_STUR, legv8_pkg::OP_STURH, legv8_pkg::OP_STURB, legv8_pkg::OP_STURW:
        dec.kind = legv8_pkg::K_STORE;
      legv8_pkg::OP_CBZ, legv8_pkg::OP_CBNZ: dec.kind = legv8_pkg::K_CB;
      legv8_pkg::OP_B: dec.kind = legv8_pkg::K_B;
      legv8_pkg::OP_BL: dec.kind = legv8_pkg::K_BL;
      legv8_pkg::OP_BR: dec.kind = legv8_pkg::K_BR;
      [legv8_pkg::OP_BEQ:legv8_pkg::OP_BLE]: dec.kind = legv8_pkg::K_BCOND;
      default: dec.kind = legv8_pkg::K_NOP;
    endcase
    case (req.req_type) inside
      legv8_pkg::OP_ADDI, legv8_pkg::OP_ADDIS, legv8_pkg::OP_SUBI, legv8_pkg::OP_SUBIS,
      legv8_pkg::OP_ANDI, legv8_pkg::OP_ANDIS, legv8_pkg::OP_EORI, legv8_pkg::OP_ORRI:
        dec.use_imm = 1'b1;
      default: dec.use_imm = 1'b0;
    endcase
    case (req.req_type) inside
      legv8_pkg::OP_ADDS, legv8_pkg::OP_ADDIS, legv8_pkg::OP_SUBS, legv8_pkg::OP_SUBIS,
      legv8_pkg::OP_ANDS, legv8_pkg::OP_ANDIS:
        dec.set_flags = 1'b1;
      default: dec.set_flags = 1'b0;
    endcase
    case (req.req_type) inside
      legv8_pkg::OP_LDUR, legv8_pkg::OP_STUR: dec.nbytes = 4'd8;
      legv8_pkg::OP_LDURW, legv8_pkg::OP_STURW: dec.nbytes = 4'd4;
      legv8_pkg::OP_LDURH, legv8_pkg::OP_STURH: dec.nbytes = 4'd2;
      legv8_pkg::OP_LDURB, legv8_pkg::OP_STURB: dec.nbytes = 4'd1;
      default: dec.nbytes = 4'd0;
    endcase
    dec.shift_right = (req.req_type == legv8_pkg::OP_LSR);
    dec.cbnz = (req.req_type == legv8_pkg::OP_CBNZ);
  end

  assign req.ready = (count != 2'(legv8_pkg::QUEUE_DEPTH));
  assign push = req.valid && req.ready;
  assign uop_valid = (count != 2'd0);
  assign pop = uop_valid && uop_ready;
  assign uop = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/legv8_back.sv
// ----------------------------------------------------------------------------
// legv8 back end
// register file, flags, pc, data memory and the result register
// ----------------------------------------------------------------------------
module legv8_back (
  input  logic clk,
  input  logic rst,
  input  logic uop_valid,
  output logic uop_ready,
  input  legv8_pkg::uop_t uop,
  input  logic [15:0] program_length,
  output logic clearing,
  legv8_res_if.source res
);

  legv8_pkg::state_t state;
  legv8_pkg::state_t state_next;

  logic [63:0] regs [32];
  logic [7:0]  mem [legv8_pkg::MEM_BYTES];
  logic [3:0]  flags;
  logic [15:0] pc;
  logic [legv8_pkg::MEM_AW-1:0] clr_addr;

  legv8_pkg::uop_t cur;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] t;
  logic [63:0] x30;
  logic [63:0] prod;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  logic [legv8_pkg::MEM_AW-1:0] mem_base;
  logic [3:0] byte_idx;
  logic [63:0] load_val;
  logic [7:0] rd_byte;

  logic [63:0] opb;
  logic [64:0] sum;
  logic [63:0] alu_val;
  logic [3:0]  alu_flags;
  logic [63:0] exec_val;
  logic        exec_wr;
  logic [4:0]  exec_reg;
  logic [15:0] exec_pc;
  logic [3:0]  exec_flags;
  logic        cond_ok;
  logic        fin_wr;
  logic [63:0] fin_val;
  logic [4:0]  fin_reg;
  legv8_pkg::res_t out_reg;
  logic res_full;
  logic res_free;
  logic take;
  logic exec_fire;
  logic mem_last;
  logic [legv8_pkg::MEM_AW-1:0] mem_addr;
  logic rd_pending;
  logic [2:0] rd_slot;
  logic commit;
  logic [63:0] commit_val;
  logic commit_pending;

  assign clearing = (state == legv8_pkg::ST_CLEAR);
  assign take = uop_valid && uop_ready;
  assign res_free = !res_full || res.ready;
  assign uop_ready = (state == legv8_pkg::ST_DONE) && !rd_pending && res_free;

  always_comb begin
    a = (cur.rn == legv8_pkg::ZERO_REG) ? 64'd0 : regs[cur.rn];
    b = (cur.rm == legv8_pkg::ZERO_REG) ? 64'd0 : regs[cur.rm];
    t = (cur.rt == legv8_pkg::ZERO_REG) ? 64'd0 : regs[cur.rt];
    x30 = regs[legv8_pkg::LINK_REG];
  end

  always_comb begin
    opb = cur.use_imm ? cur.imm : b;
    sum = '0;
    alu_val = '0;
    alu_flags = flags;
    case (cur.alu)
      legv8_pkg::ALU_ADD: begin
        sum = {1'b0, a} + {1'b0, opb};
        alu_val = sum[63:0];
        alu_flags = {alu_val[63], alu_val == 64'd0, sum[64],
                     ~(a[63] ^ opb[63]) & (a[63] ^ alu_val[63])};
      end
      legv8_pkg::ALU_SUB: begin
        sum = {1'b0, a} + {1'b0, ~opb} + 65'd1;
        alu_val = sum[63:0];
        alu_flags = {alu_val[63], alu_val == 64'd0, sum[64],
                     (a[63] ^ opb[63]) & (a[63] ^ alu_val[63])};
      end
      legv8_pkg::ALU_AND: begin
        alu_val = a & opb;
        alu_flags = {alu_val[63], alu_val == 64'd0, 2'b00};
      end
      legv8_pkg::ALU_ORR: alu_val = a | opb;
      legv8_pkg::ALU_EOR: alu_val = a ^ opb;
      default: alu_val = '0;
    endcase
  end

  always_comb begin
    case (cur.op) inside
      legv8_pkg::OP_BEQ: cond_ok = flags[2];
      legv8_pkg::OP_BNE: cond_ok = !flags[2];
      legv8_pkg::OP_BHS: cond_ok = flags[1];
      legv8_pkg::OP_BLO: cond_ok = !flags[1];
      legv8_pkg::OP_BMI: cond_ok = flags[3];
      legv8_pkg::OP_BPL: cond_ok = !flags[3];
      legv8_pkg::OP_BVS: cond_ok = flags[0];
      legv8_pkg::OP_BHI: cond_ok = flags[1] && !flags[2];
      legv8_pkg::OP_BLS: cond_ok = !(flags[1] && !flags[2]);
      legv8_pkg::OP_BGE: cond_ok = flags[3] == flags[0];
      legv8_pkg::OP_BLT: cond_ok = flags[3] != flags[0];
      legv8_pkg::OP_BGT: cond_ok = !flags[2] && (flags[3] == flags[0]);
      default: cond_ok = !(!flags[2] && (flags[3] == flags[0]));
    endcase
  end

  // execute step, results except the multiply product and load data
  always_comb begin
    exec_val = '0;
    exec_wr = 1'b0;
    exec_reg = cur.rt;
    exec_pc = pc + 16'd1;
    exec_flags = flags;
    case (cur.kind)
      legv8_pkg::K_ALU: begin
        exec_val = alu_val;
        exec_wr = 1'b1;
        if (cur.set_flags) exec_flags = alu_flags;
      end
      legv8_pkg::K_SHIFT: begin
        exec_wr = 1'b1;
        if (cur.imm[63:6] != '0) exec_val = '0;
        else if (cur.shift_right) exec_val = a >> cur.imm[5:0];
        else exec_val = a << cur.imm[5:0];
      end
      legv8_pkg::K_MUL, legv8_pkg::K_LOAD: exec_wr = 1'b1;
      legv8_pkg::K_CB: if ((t == 64'd0) != cur.cbnz) exec_pc = cur.target;
      legv8_pkg::K_B: exec_pc = cur.target;
      legv8_pkg::K_BL: begin
        exec_pc = cur.target;
        exec_val = {48'd0, pc};
        exec_wr = 1'b1;
        exec_reg = legv8_pkg::LINK_REG;
      end
      legv8_pkg::K_BR: exec_pc = x30[15:0] + 16'd1;
      legv8_pkg::K_BCOND: if (cond_ok) exec_pc = cur.target;
      default: exec_wr = 1'b0;
    endcase
  end

  // low 64 bits of the product from three 32x32 partial products
  assign mul_x = (byte_idx == 4'd2) ? a[63:32] : a[31:0];
  assign mul_y = (byte_idx == 4'd1) ? b[63:32] : b[31:0];
  assign mul_p = mul_x * mul_y;

  assign mem_addr = mem_base - legv8_pkg::MEM_AW'(byte_idx);
  assign mem_last = (byte_idx == cur.nbytes - 4'd1);
  assign exec_fire = (state == legv8_pkg::ST_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      legv8_pkg::ST_CLEAR:
        if (clr_addr == legv8_pkg::MEM_AW'(legv8_pkg::MEM_BYTES - 1))
          state_next = legv8_pkg::ST_DONE;
      legv8_pkg::ST_EXEC:
        if (cur.kind == legv8_pkg::K_LOAD || cur.kind == legv8_pkg::K_STORE)
          state_next = legv8_pkg::ST_MEM;
        else if (cur.kind == legv8_pkg::K_MUL) state_next = legv8_pkg::ST_MUL;
        else state_next = legv8_pkg::ST_DONE;
      legv8_pkg::ST_MEM: if (mem_last) state_next = legv8_pkg::ST_DONE;
      legv8_pkg::ST_MUL: if (byte_idx == 4'd2) state_next = legv8_pkg::ST_DONE;
      legv8_pkg::ST_DONE: if (take) state_next = legv8_pkg::ST_EXEC;
      default: state_next = legv8_pkg::ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= legv8_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // memory: clearing sweep, byte writes, registered byte reads
  always_ff @(posedge clk) begin
    if (state == legv8_pkg::ST_CLEAR) begin
      mem[clr_addr] <= 8'd0;
    end else if (state == legv8_pkg::ST_MEM && cur.kind == legv8_pkg::K_STORE) begin
      mem[mem_addr] <= t[8*byte_idx[2:0] +: 8];
    end
    rd_byte <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_pending <= 1'b0;
    end else begin
      if (state == legv8_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      rd_pending <= (state == legv8_pkg::ST_MEM) && (cur.kind == legv8_pkg::K_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= uop;
    end
    if (exec_fire) begin
      mem_base <= legv8_pkg::MEM_AW'(a + cur.imm);
      byte_idx <= 4'd0;
      load_val <= '0;
      fin_val <= exec_val;
      fin_reg <= exec_reg;
      fin_wr <= exec_wr && (exec_reg != legv8_pkg::ZERO_REG);
    end
    if (state == legv8_pkg::ST_MEM) begin
      byte_idx <= byte_idx + 4'd1;
      rd_slot <= byte_idx[2:0];
    end
    if (state == legv8_pkg::ST_MUL) begin
      byte_idx <= byte_idx + 4'd1;
      if (byte_idx == 4'd0) prod <= mul_p;
      else prod[63:32] <= prod[63:32] + mul_p[31:0];
    end
    if (rd_pending) begin
      load_val[8*rd_slot +: 8] <= rd_byte;
    end
  end

  // register file, flags and pc; commit happens in the done state
  always_comb begin
    commit_val = fin_val;
    if (cur.kind == legv8_pkg::K_MUL) commit_val = prod;
    else if (cur.kind == legv8_pkg::K_LOAD) commit_val = load_val;
  end

  assign commit = commit_pending && (state == legv8_pkg::ST_DONE) && !rd_pending && res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        regs[i] <= 64'd0;
      end
      regs[legv8_pkg::STACK_REG] <= 64'(legv8_pkg::MEM_BYTES - 1);
      flags <= 4'd0;
      pc <= 16'd0;
      commit_pending <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (exec_fire) begin
        flags <= exec_flags;
        pc <= exec_pc;
        commit_pending <= 1'b1;
      end
      if (commit) begin
        commit_pending <= 1'b0;
        if (fin_wr) regs[fin_reg] <= commit_val;
      end
      if (commit) res_full <= 1'b1;
      else if (res.ready) res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_reg.next_pc <= pc;
      out_reg.reg_written <= fin_wr;
      out_reg.written_reg <= fin_wr ? fin_reg : 5'd0;
      out_reg.written_value <= fin_wr ? commit_val : 64'd0;
      out_reg.flags_nzcv <= flags;
      out_reg.finished <= (pc >= program_length);
    end
  end

  assign res.valid = res_full;
  assign res.next_pc = out_reg.next_pc;
  assign res.reg_written = out_reg.reg_written;
  assign res.written_reg = out_reg.written_reg;
  assign res.written_value = out_reg.written_value;
  assign res.flags_nzcv = out_reg.flags_nzcv;
  assign res.finished = out_reg.finished;

endmodule

>>> rtl/legv8_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// legv8 subset execute unit
// executes one pre-decoded legv8 instruction per item
// ----------------------------------------------------------------------------
// usage:
//   req  : instruction items, accepted when valid and ready are high
//   res  : one result item per instruction, held until taken
//   cfg  : program_length write, to be done by the user only while the unit is idle; the unit leaves this unchecked
// execution steps:
//   alu, shift and branch items go through execute, then commit into the
//   result register; mul then runs its partial products in turn on a
//   single 32x32 multiplier; loads and stores move one byte at a time
//   (1, 2, 4 or 8 bytes) through the single byte-wide data memory
//   port, loads also waiting for the last read to land
//   a two-entry queue lets the front accept while the back works
// reset:
//   rst clears registers (x28 = memory size - 1), flags and pc, then a
//   clearing pass over all 65536 bytes zeroes the data memory; no item is
//   taken during that pass
// stalls:
//   a held result blocks the next commit; the queue then fills and
//   req.ready drops
// ----------------------------------------------------------------------------
module legv8_subset_execute_unit (
  input logic clk,
  input logic rst,
  legv8_req_if.sink req,
  legv8_res_if.source res,
  legv8_cfg_if.sink cfg
);

  logic [15:0] program_length;
  logic uop_valid;
  logic uop_ready;
  logic clearing;
  legv8_pkg::uop_t uop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 16'd0;
    end else if (cfg.valid && cfg.ready) begin
      program_length <= cfg.data;
    end
  end

  legv8_front u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .uop_valid(uop_valid),
    .uop_ready(uop_ready),
    .uop(uop)
  );

  legv8_back u_back (
    .clk(clk),
    .rst(rst),
    .uop_valid(uop_valid),
    .uop_ready(uop_ready),
    .uop(uop),
    .program_length(program_length),
    .clearing(clearing),
    .res(res)
  );

`ifndef SYNTHESIS
  a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !uop_ready)
    else $error("item issued during memory clear");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.written_value))
    else $error("result dropped while stalled");
  a_zero_reg_never_written: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.reg_written && res.written_reg == legv8_pkg::ZERO_REG))
    else $error("write to zero register reported");
`endif

endmodule

>>> tb/sv/legv8_subset_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// legv8 subset execute unit testbench
// drives instruction items through the request channel, predicts every result
// with a behavioral model of the unit and checks the result channel in order
// ----------------------------------------------------------------------------
module legv8_subset_execute_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  op;
    logic [4:0]  rt;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [31:0] imm;
    logic [15:0] target;
  } instr_t;

  class exec_scoreboard;
    logic [63:0] xreg [32];
    logic [3:0]  nzcv;
    logic [15:0] pc;
    logic [7:0]  dmem [legv8_pkg::MEM_BYTES];
    logic [15:0] prog_len;
    legv8_pkg::res_t pending [$];
    int          errors;

    function void clear();
      for (int i = 0; i < 32; i++) xreg[i] = '0;
      xreg[legv8_pkg::STACK_REG] = 64'(legv8_pkg::MEM_BYTES - 1);
      nzcv = '0;
      pc = '0;
      for (int i = 0; i < legv8_pkg::MEM_BYTES; i++) dmem[i] = '0;
      prog_len = '0;
      errors = 0;
    endfunction

    function logic [63:0] rd(logic [4:0] idx);
      return (idx == legv8_pkg::ZERO_REG) ? 64'd0 : xreg[idx];
    endfunction

    function logic [3:0] nz(logic [63:0] r);
      return {r[63], r == 0, 2'b00};
    endfunction

    function logic [3:0] add_nzcv(logic [63:0] a, logic [63:0] b, logic [63:0] r);
      return nz(r) | {2'b00, r < a, (~(a ^ b) & (a ^ r)) >> 63 != 0};
    endfunction

    function logic [3:0] sub_nzcv(logic [63:0] a, logic [63:0] b, logic [63:0] r);
      return nz(r) | {2'b00, a >= b, ((a ^ b) & (a ^ r)) >> 63 != 0};
    endfunction

    function logic [15:0] addr(logic [63:0] ea, int i);
      logic [63:0] s;
      s = ea - 64'(i);
      return s[15:0];
    endfunction

    function logic cond(legv8_pkg::op_t op);
      logic n, z, c, v;
      {n, z, c, v} = nzcv;
      case (op)
        legv8_pkg::OP_BEQ: return z;
        legv8_pkg::OP_BNE: return !z;
        legv8_pkg::OP_BHS: return c;
        legv8_pkg::OP_BLO: return !c;
        legv8_pkg::OP_BMI: return n;
        legv8_pkg::OP_BPL: return !n;
        legv8_pkg::OP_BVS: return v;
        legv8_pkg::OP_BHI: return c && !z;
        legv8_pkg::OP_BLS: return !(c && !z);
        legv8_pkg::OP_BGE: return n == v;
        legv8_pkg::OP_BLT: return n != v;
        legv8_pkg::OP_BGT: return !z && n == v;
        default: return !(!z && n == v);
      endcase
    endfunction

    function void note_instr(instr_t it);
      logic [63:0] a, b, t, imm, val, ea;
      logic [15:0] nxt;
      logic wr;
      logic [4:0] wreg;
      int nb;
      legv8_pkg::res_t r;
      a = rd(it.rn);
      b = rd(it.rm);
      t = rd(it.rt);
      imm = {{32{it.imm[31]}}, it.imm};
      ea = a + imm;
      nxt = pc + 16'd1;
      wr = 0;
      wreg = it.rt;
      val = '0;
      nb = 0;
      case (it.op)
        legv8_pkg::OP_ADD: begin val = a + b; wr = 1; end
        legv8_pkg::OP_MUL: begin val = a * b; wr = 1; end
        legv8_pkg::OP_ADDS: begin val = a + b; wr = 1; nzcv = add_nzcv(a, b, val); end
        legv8_pkg::OP_ADDI: begin val = a + imm; wr = 1; end
        legv8_pkg::OP_ADDIS: begin val = a + imm; wr = 1; nzcv = add_nzcv(a, imm, val); end
        legv8_pkg::OP_SUB: begin val = a - b; wr = 1; end
        legv8_pkg::OP_SUBS: begin val = a - b; wr = 1; nzcv = sub_nzcv(a, b, val); end
        legv8_pkg::OP_SUBI: begin val = a - imm; wr = 1; end
        legv8_pkg::OP_SUBIS: begin val = a - imm; wr = 1; nzcv = sub_nzcv(a, imm, val); end
        legv8_pkg::OP_LDUR, legv8_pkg::OP_LDURH, legv8_pkg::OP_LDURB,
        legv8_pkg::OP_LDURW: begin
          nb = (it.op == legv8_pkg::OP_LDUR) ? 8 : (it.op == legv8_pkg::OP_LDURW) ? 4 :
               (it.op == legv8_pkg::OP_LDURH) ? 2 : 1;
          for (int i = 0; i < nb; i++) val[8*i +: 8] = dmem[addr(ea, i)];
          wr = 1;
        end
        legv8_pkg::OP_STUR, legv8_pkg::OP_STURH, legv8_pkg::OP_STURB,
        legv8_pkg::OP_STURW: begin
          nb = (it.op == legv8_pkg::OP_STUR) ? 8 : (it.op == legv8_pkg::OP_STURW) ? 4 :
               (it.op == legv8_pkg::OP_STURH) ? 2 : 1;
          for (int i = 0; i < nb; i++) dmem[addr(ea, i)] = t[8*i +: 8];
        end
        legv8_pkg::OP_AND: begin val = a & b; wr = 1; end
        legv8_pkg::OP_ANDS: begin val = a & b; wr = 1; nzcv = nz(val); end
        legv8_pkg::OP_ANDI: begin val = a & imm; wr = 1; end
        legv8_pkg::OP_ANDIS: begin val = a & imm; wr = 1; nzcv = nz(val); end
        legv8_pkg::OP_CBZ: if (t == 0) nxt = it.target;
        legv8_pkg::OP_CBNZ: if (t != 0) nxt = it.target;
        legv8_pkg::OP_B: nxt = it.target;
        legv8_pkg::OP_BL: begin
          val = {48'd0, pc};
          wr = 1;
          wreg = legv8_pkg::LINK_REG;
          nxt = it.target;
        end
        legv8_pkg::OP_BR: nxt = xreg[legv8_pkg::LINK_REG][15:0] + 16'd1;
        legv8_pkg::OP_LSL: begin val = (imm >= 64) ? 64'd0 : a << imm[5:0]; wr = 1; end
        legv8_pkg::OP_LSR: begin val = (imm >= 64) ? 64'd0 : a >> imm[5:0]; wr = 1; end
        legv8_pkg::OP_EOR: begin val = a ^ b; wr = 1; end
        legv8_pkg::OP_EORI: begin val = a ^ imm; wr = 1; end
        legv8_pkg::OP_ORR: begin val = a | b; wr = 1; end
        legv8_pkg::OP_ORRI: begin val = a | imm; wr = 1; end
        default:
          if (it.op >= legv8_pkg::OP_BEQ && it.op <= legv8_pkg::OP_BLE &&
              cond(legv8_pkg::op_t'(it.op))) nxt = it.target;
      endcase
      if (wr && wreg == legv8_pkg::ZERO_REG) wr = 0;
      if (wr) xreg[wreg] = val;
      else begin
        wreg = '0;
        val = '0;
      end
      pc = nxt;
      r.next_pc = nxt;
      r.reg_written = wr;
      r.written_reg = wreg;
      r.written_value = val;
      r.flags_nzcv = nzcv;
      r.finished = nxt >= prog_len;
      pending = {pending, r};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(legv8_pkg::res_t got);
      legv8_pkg::res_t w;
      if (pending.size() == 0) begin
        report("result with nothing expected", 64'd0, 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.next_pc !== w.next_pc) report("next_pc", got.next_pc, w.next_pc);
      if (got.reg_written !== w.reg_written)
        report("reg_written", got.reg_written, w.reg_written);
      if (got.written_reg !== w.written_reg)
        report("written_reg", got.written_reg, w.written_reg);
      if (got.written_value !== w.written_value)
        report("written_value", got.written_value, w.written_value);
      if (got.flags_nzcv !== w.flags_nzcv) report("flags_nzcv", got.flags_nzcv, w.flags_nzcv);
      if (got.finished !== w.finished) report("finished", got.finished, w.finished);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  int   send_idle = 17;
  int   recv_idle = 61;
  logic hold_off = 0;

  legv8_req_if req ();
  legv8_res_if res ();
  legv8_cfg_if cfg ();

  legv8_subset_execute_unit i_dut (.clk(clk), .rst(rst), .req(req), .res(res), .cfg(cfg));

  exec_scoreboard exec_model = new();

  always #5 clk = ~clk;

  initial begin
    req.valid = 0;
    req.req_type = '0;
    req.target_reg = '0;
    req.base_reg = '0;
    req.other_reg = '0;
    req.immediate = '0;
    req.branch_target = '0;
    res.ready = 0;
    cfg.valid = 0;
    cfg.data = '0;
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      legv8_pkg::res_t r;
      r.next_pc = res.next_pc;
      r.reg_written = res.reg_written;
      r.written_reg = res.written_reg;
      r.written_value = res.written_value;
      r.flags_nzcv = res.flags_nzcv;
      r.finished = res.finished;
      exec_model.check_result(r);
    end
    res.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_instr(instr_t it);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.req_type <= it.op;
    req.target_reg <= it.rt;
    req.base_reg <= it.rn;
    req.other_reg <= it.rm;
    req.immediate <= it.imm;
    req.branch_target <= it.target;
    do @(posedge clk); while (!req.ready);
    exec_model.note_instr(it);
  endtask

  task automatic write_length(logic [15:0] len);
    cfg.valid <= 1;
    cfg.data <= len;
    do @(posedge clk); while (!cfg.ready);
    exec_model.prog_len = len;
    cfg.valid <= 0;
  endtask

  task automatic drain();
    req.valid <= 0;
    while (exec_model.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic instr_t mk(logic [5:0] op, logic [4:0] rt, logic [4:0] rn,
                                logic [4:0] rm, logic [31:0] imm, logic [15:0] tgt);
    instr_t it;
    it.op = op;
    it.rt = rt;
    it.rn = rn;
    it.rm = rm;
    it.imm = imm;
    it.target = tgt;
    return it;
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int k;
    it.op = 6'($urandom_range(44));
    if ($urandom_range(49) == 0) it.op = 6'($urandom_range(63, 45));
    it.rt = pick_reg();
    it.rn = pick_reg();
    it.rm = pick_reg();
    k = $urandom_range(5);
    case (k)
      0: it.imm = $urandom;
      1: it.imm = 32'($urandom_range(70));
      2: it.imm = -32'($urandom_range(40));
      3: it.imm = {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom)};
      default: it.imm = 32'($urandom_range(255));
    endcase
    if (it.op inside {legv8_pkg::OP_LDUR, legv8_pkg::OP_LDURH, legv8_pkg::OP_LDURB,
                      legv8_pkg::OP_LDURW, legv8_pkg::OP_STUR, legv8_pkg::OP_STURH,
                      legv8_pkg::OP_STURB, legv8_pkg::OP_STURW} && $urandom_range(1)) begin
      it.rn = ($urandom_range(1)) ? legv8_pkg::STACK_REG : legv8_pkg::ZERO_REG;
      it.imm = -32'($urandom_range(64));
    end
    it.target = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300));
    return it;
  endfunction

  initial begin
    instr_t it;
    repeat (5) @(posedge clk);
    rst <= 0;
    exec_model.clear();
    write_length(16'd20);
    send_instr(mk(legv8_pkg::OP_ADDI, 1, legv8_pkg::ZERO_REG, 0, 32'h7fffffff, 0));
    send_instr(mk(legv8_pkg::OP_SUBI, 2, legv8_pkg::ZERO_REG, 0, 32'h80000000, 0));
    send_instr(mk(legv8_pkg::OP_ADDIS, 3, 2, 0, 32'hffffffff, 0));
    send_instr(mk(legv8_pkg::OP_ADDS, 4, 2, 2, 0, 0));
    send_instr(mk(legv8_pkg::OP_SUBS, 5, legv8_pkg::ZERO_REG, 1, 0, 0));
    send_instr(mk(legv8_pkg::OP_SUBIS, 31, 1, 0, 32'h7fffffff, 0));
    send_instr(mk(legv8_pkg::OP_MUL, 6, 2, 3, 0, 0));
    send_instr(mk(legv8_pkg::OP_LSL, 7, 3, 0, 63, 0));
    send_instr(mk(legv8_pkg::OP_LSR, 8, 3, 0, 64, 0));
    send_instr(mk(legv8_pkg::OP_LSR, 9, 3, 0, 32'hffffffff, 0));
    send_instr(mk(legv8_pkg::OP_STUR, 3, legv8_pkg::STACK_REG, 0, 0, 0));
    send_instr(mk(legv8_pkg::OP_LDURW, 10, legv8_pkg::STACK_REG, 0, 32'hfffffffe, 0));
    send_instr(mk(legv8_pkg::OP_STURB, 6, legv8_pkg::ZERO_REG, 0, 0, 0));
    send_instr(mk(legv8_pkg::OP_LDURH, 11, legv8_pkg::ZERO_REG, 0, 1, 0));
    send_instr(mk(legv8_pkg::OP_ANDIS, 12, 3, 0, 32'h80000000, 0));
    send_instr(mk(legv8_pkg::OP_CBZ, legv8_pkg::ZERO_REG, 0, 0, 0, 16'hffff));
    send_instr(mk(legv8_pkg::OP_CBNZ, legv8_pkg::ZERO_REG, 0, 0, 0, 16'd5));
    send_instr(mk(legv8_pkg::OP_BL, 0, 0, 0, 0, 16'd9));
    send_instr(mk(legv8_pkg::OP_BR, 0, 0, 0, 0, 0));
    send_instr(mk(legv8_pkg::OP_BL, 0, 0, 0, 0, 16'hffff));
    send_instr(mk(legv8_pkg::OP_BR, 0, 0, 0, 0, 0));
    send_instr(mk(6'd63, 0, 0, 0, 0, 0));
    send_instr(mk(legv8_pkg::OP_BLE, 0, 0, 0, 0, 16'd3));
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_length(ph == 0 ? 16'd0 : ph == 1 ? 16'hffff : 16'($urandom_range(300)));
      if (ph == 1) begin
        send_idle = 61;
        recv_idle = 17;
        hold_off <= 1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_off <= 0;
          end
        join_none
      end
      if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < 230; n++) begin
        it = rand_instr();
        send_instr(it);
      end
      drain();
    end
    if (exec_model.errors == 0 && exec_model.pending.size() == 0) begin
      $display("** legv8_subset_execute_unit: PASSED **");
    end else begin
      $display("** legv8_subset_execute_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("** legv8_subset_execute_unit: FAILED **");
    $finish;
  end
endmodule
